FILE: design/adsr_pkg.sv
// Package for the ADSR envelope generator: types, codes and constants.
package adsr_pkg;

    localparam int VOL_W    = 17;
    localparam int VEL_W    = 16;
    localparam int GAIN_W   = 16;
    localparam int LEN_W    = 32;
    localparam int DT_W     = 16;
    localparam int PHASE_W  = 3;
    localparam int GAIN_FRAC = 14;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    localparam logic [VOL_W-1:0]  VOL_MAX = 17'd131071;

    // floor(x / 10) == (x * FLOOR_RECIP) >> FLOOR_SHIFT for x < 2^22 / 6
    localparam logic [18:0] FLOOR_RECIP = 19'd419431;
    localparam int          FLOOR_SHIFT = 22;

    localparam logic [GAIN_W-1:0] ATTACK_GAIN_RST  = 16'd19661;
    localparam logic [GAIN_W-1:0] DECAY_GAIN_RST   = 16'd16302;
    localparam logic [GAIN_W-1:0] RELEASE_GAIN_RST = 16'd16384;

    localparam logic [1:0] REG_ATTACK_GAIN  = 2'd0;
    localparam logic [1:0] REG_DECAY_GAIN   = 2'd1;
    localparam logic [1:0] REG_RELEASE_GAIN = 2'd2;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    typedef enum logic [PHASE_W-1:0] {
        PH_NOTE_ON = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4,
        PH_OFF     = 3'd5
    } t_phase;

    typedef struct packed {
        logic              command;
        logic [LEN_W-1:0]  duration_us;
        logic [VEL_W-1:0]  velocity;
        logic [DT_W-1:0]   elapsed_us;
    } t_in_item;

    typedef struct packed {
        logic [VOL_W-1:0]   envelope;
        logic [PHASE_W-1:0] phase;
    } t_out_item;

    typedef struct packed {
        t_phase            phase;
        logic [VOL_W-1:0]  volume;
        logic [VEL_W-1:0]  velocity;
        logic [LEN_W-1:0]  length;
        logic [LEN_W-1:0]  elapsed;
        logic [VEL_W-1:0]  floor9;
    } t_env_state;

    typedef struct packed {
        logic [GAIN_W-1:0] attack;
        logic [GAIN_W-1:0] decay;
        logic [GAIN_W-1:0] release_g;
    } t_gains;

endpackage

FILE: design/adsr_envelope_generator.sv
// Top level of the ADSR envelope generator: handshakes, registers, config port.
//
//  channel  direction  handshake                 payload
//  in       input      i_in_valid / o_in_stall   i_in_data  (t_in_item)
//  out      output     o_out_valid / i_out_stall o_out_data (t_out_item)
//  config   input      psel/penable/pwrite/pready paddr, pwdata, prdata
//
// Each transaction passes the input register, then the envelope update into
// the result register. One transaction per cycle unless a stalled result holds it up.
// Synchronous active-low reset; no clearing pass. A stalled result holds the
// result register; start commands still drain, step commands wait on it.
module adsr_envelope_generator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  adsr_pkg::t_in_item           i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output adsr_pkg::t_out_item          o_out_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [adsr_pkg::ADDR_W-1:0]  paddr,
    input  logic [adsr_pkg::DATA_W-1:0]  pwdata,
    output logic [adsr_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);

    logic                  r_in_vld;
    adsr_pkg::t_in_item    r_in;
    logic                  r_out_vld;
    adsr_pkg::t_out_item   r_out;
    adsr_pkg::t_env_state  r_state;
    adsr_pkg::t_gains      r_gains;

    adsr_pkg::t_env_state  n_state;
    adsr_pkg::t_out_item   n_out;
    logic                  has_result;
    logic                  out_free;
    logic                  advance;
    logic                  in_take;
    logic                  cfg_wr;

    adsr_core u_core (
        .i_item       (r_in),
        .i_state      (r_state),
        .i_gains      (r_gains),
        .o_state      (n_state),
        .o_result     (n_out),
        .o_has_result (has_result)
    );

    assign out_free   = !r_out_vld || !i_out_stall;
    assign advance    = r_in_vld && (!has_result || out_free);
    assign in_take    = !r_in_vld || advance;
    assign o_in_stall = !in_take;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= i_in_valid;
        end
        if (in_take && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance && has_result) begin
            r_out_vld <= 1'b1;
        end else if (out_free) begin
            r_out_vld <= 1'b0;
        end
        if (advance && has_result) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase    <= adsr_pkg::PH_OFF;
            r_state.volume   <= '0;
            r_state.velocity <= '0;
            r_state.length   <= '0;
            r_state.elapsed  <= '0;
            r_state.floor9   <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.attack    <= adsr_pkg::ATTACK_GAIN_RST;
            r_gains.decay     <= adsr_pkg::DECAY_GAIN_RST;
            r_gains.release_g <= adsr_pkg::RELEASE_GAIN_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                adsr_pkg::REG_ATTACK_GAIN:  r_gains.attack    <= pwdata[adsr_pkg::GAIN_W-1:0];
                adsr_pkg::REG_DECAY_GAIN:   r_gains.decay     <= pwdata[adsr_pkg::GAIN_W-1:0];
                adsr_pkg::REG_RELEASE_GAIN: r_gains.release_g <= pwdata[adsr_pkg::GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            adsr_pkg::REG_ATTACK_GAIN:  prdata = {16'h0000, r_gains.attack};
            adsr_pkg::REG_DECAY_GAIN:   prdata = {16'h0000, r_gains.decay};
            adsr_pkg::REG_RELEASE_GAIN: prdata = {16'h0000, r_gains.release_g};
            default:                    prdata = '0;
        endcase
    end

endmodule

FILE: design/adsr_core.sv
// Next-state and result logic for one envelope transaction.
module adsr_core (
    input  adsr_pkg::t_in_item   i_item,
    input  adsr_pkg::t_env_state i_state,
    input  adsr_pkg::t_gains     i_gains,
    output adsr_pkg::t_env_state o_state,
    output adsr_pkg::t_out_item  o_result,
    output logic                 o_has_result
);

    localparam int UNIT_W = adsr_pkg::LEN_W - 4;

    adsr_pkg::t_phase               eff_phase;
    logic [adsr_pkg::VOL_W-1:0]     eff_vol;
    logic [UNIT_W-1:0]              unit;
    logic [adsr_pkg::LEN_W-1:0]     span;
    logic [adsr_pkg::LEN_W:0]       tsum;
    logic [adsr_pkg::LEN_W-1:0]     tsat;
    logic                           running;
    logic [adsr_pkg::GAIN_W-1:0]    gain;
    logic [adsr_pkg::VOL_W+adsr_pkg::GAIN_W-1:0] prod;
    logic [adsr_pkg::VOL_W+1:0]     shifted;
    logic [adsr_pkg::VOL_W-1:0]     scaled;
    logic [adsr_pkg::VOL_W-1:0]     ceil2;
    logic [adsr_pkg::VOL_W-1:0]     floor9;
    logic [19:0]                    vel9;
    logic [38:0]                    vel9_q;

    always_comb begin
        eff_phase = i_state.phase;
        eff_vol   = i_state.volume;
        if (i_state.phase == adsr_pkg::PH_NOTE_ON) begin
            eff_phase = adsr_pkg::PH_ATTACK;
            eff_vol   = {1'b0, i_state.velocity};
        end

        unit = i_state.length[adsr_pkg::LEN_W-1:4];
        unique case (eff_phase)
            adsr_pkg::PH_SUSTAIN: span = {1'b0, unit, 3'b000} + {3'b000, unit, 1'b0};
            adsr_pkg::PH_RELEASE: span = {2'b00, unit, 2'b00};
            default:              span = {4'b0000, unit};
        endcase

        tsum    = {1'b0, i_state.elapsed} + {{(adsr_pkg::LEN_W-adsr_pkg::DT_W+1){1'b0}},
                                             i_item.elapsed_us};
        tsat    = tsum[adsr_pkg::LEN_W] ? '1 : tsum[adsr_pkg::LEN_W-1:0];
        running = tsat < span;

        unique case (eff_phase)
            adsr_pkg::PH_ATTACK: gain = i_gains.attack;
            adsr_pkg::PH_DECAY:  gain = i_gains.decay;
            default:             gain = i_gains.release_g;
        endcase

        prod    = eff_vol * gain;
        shifted = prod[adsr_pkg::VOL_W+adsr_pkg::GAIN_W-1:adsr_pkg::GAIN_FRAC];
        scaled  = (shifted > {2'b00, adsr_pkg::VOL_MAX}) ? adsr_pkg::VOL_MAX
                                                          : shifted[adsr_pkg::VOL_W-1:0];
        ceil2   = {i_state.velocity, 1'b0};
        floor9  = {1'b0, i_state.floor9};

        vel9   = {1'b0, i_item.velocity, 3'b000} + {4'b0000, i_item.velocity};
        vel9_q = vel9 * adsr_pkg::FLOOR_RECIP;

        o_state      = i_state;
        o_has_result = 1'b0;

        if (i_item.command == adsr_pkg::CMD_START) begin
            o_state.length   = i_item.duration_us;
            o_state.velocity = i_item.velocity;
            o_state.phase    = adsr_pkg::PH_NOTE_ON;
            o_state.elapsed  = '0;
            o_state.floor9   = vel9_q[adsr_pkg::FLOOR_SHIFT+adsr_pkg::VEL_W-1:
                                      adsr_pkg::FLOOR_SHIFT];
        end else begin
            o_has_result   = 1'b1;
            o_state.phase  = eff_phase;
            o_state.volume = eff_vol;
            if (i_state.phase == adsr_pkg::PH_NOTE_ON) begin
                o_state.elapsed = '0;
            end
            unique case (eff_phase)
                adsr_pkg::PH_ATTACK: begin
                    o_state.elapsed = running ? tsat : '0;
                    if (running) begin
                        o_state.volume = (scaled > ceil2) ? ceil2 : scaled;
                    end else begin
                        o_state.phase = adsr_pkg::PH_DECAY;
                    end
                end
                adsr_pkg::PH_DECAY: begin
                    o_state.elapsed = running ? tsat : '0;
                    if (running) begin
                        o_state.volume = (scaled < floor9) ? floor9 : scaled;
                    end else begin
                        o_state.phase = adsr_pkg::PH_SUSTAIN;
                    end
                end
                adsr_pkg::PH_SUSTAIN: begin
                    o_state.elapsed = running ? tsat : '0;
                    if (!running) begin
                        o_state.phase = adsr_pkg::PH_RELEASE;
                    end
                end
                adsr_pkg::PH_RELEASE: begin
                    o_state.elapsed = tsat;
                    if (running) begin
                        o_state.volume = scaled;
                    end else begin
                        o_state.phase = adsr_pkg::PH_OFF;
                    end
                end
                default: begin
                end
            endcase
        end

        o_result.envelope = o_state.volume;
        o_result.phase    = o_state.phase;
    end

endmodule
